[sv/epoch_seconds_to_calendar_core_defines.svh]
// Assertion macros for the checker file of the epoch to calendar core.
`ifndef EPOCH_SECONDS_TO_CALENDAR_CORE_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_CORE_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define ES2C_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define ES2C_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[sv/es2c_pkg.sv]
// Shared types and constants of the epoch to calendar core.
package es2c_pkg;

   // Accepted range of the seconds count: years 0 to 9999.
   localparam logic signed [38:0] SECS_MIN = -39'sd62167219200;
   localparam logic signed [38:0] SECS_MAX = 39'sd253402300799;
   localparam logic [38:0] SECS_OFS = 39'd62167219200;

   // Decoupling queue between the front and the back.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

   // Constant divisors and their truncated reciprocals.
   localparam int unsigned DAY_DIV = 675;        // 86400 / 128
   localparam int unsigned DAY_RECIP = 6362914;  // 2^32 / 675
   localparam int unsigned DAYS_PER_ERA = 146097;
   localparam int unsigned ERA_RECIP = 28;       // 2^22 / 146097
   localparam int unsigned ERA_SHIFT = 146037;   // one era less the Jan/Feb days
   localparam int unsigned WEEK_SHIFT = 6;
   localparam int unsigned WEEK_RECIP = 599186;  // 2^22 / 7
   localparam int unsigned HOUR_RECIP = 36;      // 2^17 / 3600
   localparam int unsigned SECS_PER_HOUR = 3600;
   localparam int unsigned D1460_RECIP = 179;    // 2^18 / 1460
   localparam int unsigned D36524_RECIP = 7;     // 2^18 / 36524
   localparam int unsigned MIN_RECIP = 68;       // 2^12 / 60
   localparam int unsigned YEAR_RECIP = 718;     // 2^18 / 365

   // One queued beat: the offset seconds and the range flag.
   typedef struct packed {
      logic        out_of_range;
      logic [38:0] secs_ofs;
   } es2c_item_type;

   // Time of day and weekday fields carried down the back pipeline.
   typedef struct packed {
      logic       out_of_range;
      logic [2:0] weekday;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } es2c_tag_type;

   // First day of year of each month in the March-based year.
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] start;
      case (mp)
         4'd0:    start = 9'd0;
         4'd1:    start = 9'd31;
         4'd2:    start = 9'd61;
         4'd3:    start = 9'd92;
         4'd4:    start = 9'd122;
         4'd5:    start = 9'd153;
         4'd6:    start = 9'd184;
         4'd7:    start = 9'd214;
         4'd8:    start = 9'd245;
         4'd9:    start = 9'd275;
         4'd10:   start = 9'd306;
         4'd11:   start = 9'd337;
         default: start = 9'd0;
      endcase
      return start;
   endfunction

endpackage

[sv/es2c_front.sv]
// Front end: range check, offset to a nonnegative count and the decoupling queue.
module es2c_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   input  logic signed [38:0]      req_epoch_seconds,
   output logic                    req_full,
   input  logic                    deq,
   output es2c_pkg::es2c_item_type item,
   output logic                    item_valid
);
   import es2c_pkg::*;

   es2c_item_type     queue_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W:0]   count_ff;
   es2c_item_type     class_item;
   logic              push_ok;
   logic              pop_ok;

   // Out-of-range inputs travel as offset zero with the flag set.
   always_comb begin
      class_item.out_of_range = (req_epoch_seconds < SECS_MIN) ||
                                (req_epoch_seconds > SECS_MAX);
      class_item.secs_ofs = class_item.out_of_range ? '0 :
                            (req_epoch_seconds + SECS_OFS);
   end

   assign req_full   = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = queue_mem_ff[rd_ptr_ff];
   assign push_ok    = req_push && !req_full;
   assign pop_ok     = deq && item_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_ok) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop_ok) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push_ok && !pop_ok) begin
            count_ff <= count_ff + (QPTR_W + 1)'(1);
         end else if (pop_ok && !push_ok) begin
            count_ff <= count_ff - (QPTR_W + 1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_mem_ff[wr_ptr_ff] <= class_item;
      end
   end

endmodule

[sv/es2c_back.sv]
// Back end: seventeen-stage conversion pipeline with a stall on a full output stage.
module es2c_back (
   input  logic                    clock,
   input  logic                    reset,
   input  es2c_pkg::es2c_item_type item,
   input  logic                    item_valid,
   output logic                    deq,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [13:0]             rsp_year,
   output logic [3:0]              rsp_month,
   output logic [4:0]              rsp_day_of_month,
   output logic [4:0]              rsp_hour,
   output logic [5:0]              rsp_minute,
   output logic [5:0]              rsp_second,
   output logic [2:0]              rsp_weekday,
   output logic                    rsp_out_of_range
);
   import es2c_pkg::*;

   localparam int unsigned NSTG = 17;

   logic [NSTG-1:0] vld_ff;
   logic            adv;
   es2c_tag_type    tag_ff [1:NSTG];
   logic [4:0]      era_ff [7:14];
   logic [17:0]     doe_ff [7:14];
   logic [11:0]     remh_ff [7:8];

   logic [21:0] s1_q_ff, s2_q_ff;
   logic [31:0] s1_v_ff;
   logic [6:0]  s1_lo_ff, s2_lo_ff;
   logic [10:0] s2_r_ff;
   logic [21:0] s3_days_ff;
   logic [16:0] s3_tod_ff, s4_tod_ff, s5_tod_ff;
   logic [21:0] s4_z_ff, s4_w_ff, s5_z_ff, s5_w_ff;
   logic [4:0]  s5_qe_ff, s6_qe_ff;
   logic [19:0] s5_qw_ff;
   logic [5:0]  s5_qh_ff, s6_qh_ff;
   logic [18:0] s6_re_ff;
   logic [3:0]  s6_rw_ff;
   logic [12:0] s6_rh_ff;
   logic [7:0]  s8_q1_ff, s9_q1_ff;
   logic [2:0]  s8_q2_ff, s9_q2_ff;
   logic [6:0]  s8_qm_ff, s9_qm_ff;
   logic [11:0] s9_r1_ff;
   logic [16:0] s9_r2_ff;
   logic [6:0]  s9_rm_ff;
   logic [6:0]  s10_c1_ff;
   logic [2:0]  s10_c2_ff;
   logic [17:0] s11_t_ff, s12_t_ff;
   logic [9:0]  s12_qy_ff, s13_qy_ff, s13_ry_ff;
   logic [8:0]  s14_yoe_ff;
   logic [8:0]  s15_doy_ff, s16_doy_ff;
   logic [13:0] s15_yb_ff, s16_yb_ff;
   logic [3:0]  s16_mp_ff;
   logic [13:0] s17_year_ff;
   logic [3:0]  s17_month_ff;
   logic [4:0]  s17_dom_ff;

   logic [54:0] day_prod;
   logic [31:0] day_back;
   logic [10:0] day_rfix;
   logic [26:0] era_prod;
   logic [41:0] wk_prod;
   logic [22:0] hr_prod;
   logic [21:0] era_back;
   logic [21:0] wk_back;
   logic [16:0] hr_back;
   logic [18:0] era_rfix;
   logic [3:0]  wk_rfix;
   logic [12:0] hr_rfix;
   logic [5:0]  hr_qfix;
   logic [25:0] c1_prod;
   logic [20:0] c2_prod;
   logic [18:0] m_prod;
   logic [17:0] c1_back, c2_back;
   logic [11:0] m_back;
   logic [7:0]  c1_fix;
   logic [2:0]  c2_fix;
   logic [6:0]  m_qfix, m_rfix;
   logic [27:0] y_prod;
   logic [17:0] y_back;
   logic [9:0]  yoe_fix;
   logic [1:0]  cent;
   logic [17:0] doy_wide;
   logic [3:0]  mp_cnt;

   // The whole pipe moves unless a finished beat waits at the output.
   assign adv = !vld_ff[NSTG-1] || rsp_pop;
   assign deq = adv;

   // Each division is a reciprocal estimate, a back-multiply and one correction.
   always_comb begin
      day_prod = 55'(item.secs_ofs[38:7]) * 55'(DAY_RECIP);
      day_back = s1_v_ff - 32'(s1_q_ff) * 32'(DAY_DIV);
      day_rfix = (s2_r_ff >= 11'(DAY_DIV)) ? (s2_r_ff - 11'(DAY_DIV)) : s2_r_ff;

      era_prod = 27'(s4_z_ff) * 27'(ERA_RECIP);
      wk_prod  = 42'(s4_w_ff) * 42'(WEEK_RECIP);
      hr_prod  = 23'(s4_tod_ff) * 23'(HOUR_RECIP);
      era_back = s5_z_ff - 22'(s5_qe_ff) * 22'(DAYS_PER_ERA);
      wk_back  = s5_w_ff - 22'(s5_qw_ff) * 22'(7);
      hr_back  = s5_tod_ff - 17'(s5_qh_ff) * 17'(SECS_PER_HOUR);
      era_rfix = (s6_re_ff >= 19'(DAYS_PER_ERA)) ? (s6_re_ff - 19'(DAYS_PER_ERA)) : s6_re_ff;
      wk_rfix  = (s6_rw_ff >= 4'd7) ? (s6_rw_ff - 4'd7) : s6_rw_ff;
      hr_qfix  = (s6_rh_ff >= 13'(SECS_PER_HOUR)) ? (s6_qh_ff + 6'd1) : s6_qh_ff;
      hr_rfix  = (s6_rh_ff >= 13'(SECS_PER_HOUR)) ? (s6_rh_ff - 13'(SECS_PER_HOUR))
                                                 : s6_rh_ff;

      c1_prod = 26'(doe_ff[7]) * 26'(D1460_RECIP);
      c2_prod = 21'(doe_ff[7]) * 21'(D36524_RECIP);
      m_prod  = 19'(remh_ff[7]) * 19'(MIN_RECIP);
      c1_back = doe_ff[8] - 18'(s8_q1_ff) * 18'(1460);
      c2_back = doe_ff[8] - 18'(s8_q2_ff) * 18'(36524);
      m_back  = remh_ff[8] - 12'(s8_qm_ff) * 12'(60);
      c1_fix  = (s9_r1_ff >= 12'd1460) ? (s9_q1_ff + 8'd1) : s9_q1_ff;
      c2_fix  = (s9_r2_ff >= 17'd36524) ? (s9_q2_ff + 3'd1) : s9_q2_ff;
      m_qfix  = (s9_rm_ff >= 7'd60) ? (s9_qm_ff + 7'd1) : s9_qm_ff;
      m_rfix  = (s9_rm_ff >= 7'd60) ? (s9_rm_ff - 7'd60) : s9_rm_ff;

      y_prod  = 28'(s11_t_ff) * 28'(YEAR_RECIP);
      y_back  = s12_t_ff - 18'(s12_qy_ff) * 18'(365);
      yoe_fix = (s13_ry_ff >= 10'd365) ? (s13_qy_ff + 10'd1) : s13_qy_ff;

      cent = 2'(s14_yoe_ff >= 9'd100) + 2'(s14_yoe_ff >= 9'd200) +
             2'(s14_yoe_ff >= 9'd300);
      doy_wide = doe_ff[14] - (18'(s14_yoe_ff) * 18'(365) + 18'(s14_yoe_ff[8:2]) -
                               18'(cent));

      mp_cnt = '0;
      for (int i = 1; i < 12; i++) begin
         mp_cnt = mp_cnt + 4'(s15_doy_ff >= month_start(4'(i)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTG-2:0], item_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 2; i <= NSTG; i++) begin
            if (i != 7 && i != 10) begin
               tag_ff[i] <= tag_ff[i-1];
            end
         end
         for (int i = 8; i <= 14; i++) begin
            era_ff[i] <= era_ff[i-1];
            doe_ff[i] <= doe_ff[i-1];
         end
         remh_ff[8] <= remh_ff[7];

         // Offset seconds split into days since year 0 and second of day.
         tag_ff[1]    <= '{out_of_range: item.out_of_range, default: '0};
         s1_q_ff      <= day_prod[53:32];
         s1_v_ff      <= item.secs_ofs[38:7];
         s1_lo_ff     <= item.secs_ofs[6:0];
         s2_r_ff      <= day_back[10:0];
         s2_q_ff      <= s1_q_ff;
         s2_lo_ff     <= s1_lo_ff;
         s3_days_ff   <= (s2_r_ff >= 11'(DAY_DIV)) ? (s2_q_ff + 22'd1) : s2_q_ff;
         s3_tod_ff    <= {day_rfix[9:0], s2_lo_ff};

         // Era, weekday and hour.
         s4_z_ff      <= s3_days_ff + 22'(ERA_SHIFT);
         s4_w_ff      <= s3_days_ff + 22'(WEEK_SHIFT);
         s4_tod_ff    <= s3_tod_ff;
         s5_qe_ff     <= era_prod[26:22];
         s5_qw_ff     <= wk_prod[41:22];
         s5_qh_ff     <= hr_prod[22:17];
         s5_z_ff      <= s4_z_ff;
         s5_w_ff      <= s4_w_ff;
         s5_tod_ff    <= s4_tod_ff;
         s6_re_ff     <= era_back[18:0];
         s6_rw_ff     <= wk_back[3:0];
         s6_rh_ff     <= hr_back[12:0];
         s6_qe_ff     <= s5_qe_ff;
         s6_qh_ff     <= s5_qh_ff;
         era_ff[7]    <= (s6_re_ff >= 19'(DAYS_PER_ERA)) ? (s6_qe_ff + 5'd1) : s6_qe_ff;
         doe_ff[7]    <= era_rfix[17:0];
         remh_ff[7]   <= hr_rfix[11:0];
         tag_ff[7]    <= '{out_of_range: tag_ff[6].out_of_range,
                           weekday: wk_rfix[2:0] + 3'd1,
                           hour: hr_qfix[4:0],
                           default: '0};

         // Century corrections of the day of era, minute and second.
         s8_q1_ff     <= c1_prod[25:18];
         s8_q2_ff     <= c2_prod[20:18];
         s8_qm_ff     <= m_prod[18:12];
         s9_r1_ff     <= c1_back[11:0];
         s9_r2_ff     <= c2_back[16:0];
         s9_rm_ff     <= m_back[6:0];
         s9_q1_ff     <= s8_q1_ff;
         s9_q2_ff     <= s8_q2_ff;
         s9_qm_ff     <= s8_qm_ff;
         s10_c1_ff    <= c1_fix[6:0];
         s10_c2_ff    <= c2_fix;
         tag_ff[10]   <= '{out_of_range: tag_ff[9].out_of_range,
                           weekday: tag_ff[9].weekday,
                           hour: tag_ff[9].hour,
                           minute: m_qfix[5:0],
                           second: m_rfix[5:0]};

         // Year of era, day of year and month.
         s11_t_ff     <= doe_ff[10] - 18'(s10_c1_ff) + 18'(s10_c2_ff) -
                         18'(doe_ff[10] == 18'd146096);
         s12_qy_ff    <= y_prod[27:18];
         s12_t_ff     <= s11_t_ff;
         s13_ry_ff    <= y_back[9:0];
         s13_qy_ff    <= s12_qy_ff;
         s14_yoe_ff   <= yoe_fix[8:0];
         s15_doy_ff   <= doy_wide[8:0];
         s15_yb_ff    <= 14'(s14_yoe_ff) + 14'(era_ff[14]) * 14'(400);
         s16_mp_ff    <= mp_cnt;
         s16_doy_ff   <= s15_doy_ff;
         s16_yb_ff    <= s15_yb_ff;
         s17_year_ff  <= s16_yb_ff - 14'd400 + 14'(s16_mp_ff >= 4'd10);
         s17_month_ff <= (s16_mp_ff < 4'd10) ? (s16_mp_ff + 4'd3) : (s16_mp_ff - 4'd9);
         s17_dom_ff   <= 5'(s16_doy_ff - month_start(s16_mp_ff) + 9'd1);
      end
   end

   // An out-of-range beat shows all fields as zero.
   always_comb begin
      rsp_empty        = !vld_ff[NSTG-1];
      rsp_out_of_range = tag_ff[NSTG].out_of_range;
      if (tag_ff[NSTG].out_of_range) begin
         rsp_year         = '0;
         rsp_month        = '0;
         rsp_day_of_month = '0;
         rsp_hour         = '0;
         rsp_minute       = '0;
         rsp_second       = '0;
         rsp_weekday      = '0;
      end else begin
         rsp_year         = s17_year_ff;
         rsp_month        = s17_month_ff;
         rsp_day_of_month = s17_dom_ff;
         rsp_hour         = tag_ff[NSTG].hour;
         rsp_minute       = tag_ff[NSTG].minute;
         rsp_second       = tag_ff[NSTG].second;
         rsp_weekday      = tag_ff[NSTG].weekday;
      end
   end

endmodule

[sv/epoch_seconds_to_calendar_core.sv]
// Top level of the epoch seconds to calendar date and time converter.
//
// This core turns a signed count of seconds since 1970-01-01 00:00:00 into the
// proleptic Gregorian year, month and day, the hour, minute and second, and the
// day of the week (1 for Sunday through 7 for Saturday). Counts outside years 0
// to 9999 come back with out_of_range set and every other field zero. Both sides
// behave like a queue: a request beat is taken when req_push is high and
// req_full is low, and the oldest result beat sits on the rsp_ ports while
// rsp_empty is low and leaves when rsp_pop is high. One beat enters per cycle
// and one result leaves per cycle for as long as the consumer keeps popping.
// An accepted beat passes through the four-entry front queue and then walks
// the 17-stage conversion pipeline, a length set by the chain of constant
// divisions (86400, 146097, the century terms, 365), each done as a
// reciprocal multiply, a back multiply and a single correction. When the
// result at the head of the pipeline is not popped the pipeline holds, and
// the front queue keeps taking beats until it fills. No configuration and no
// state beyond the beats in flight; reset only empties the queue and
// pipeline.
module epoch_seconds_to_calendar_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic signed [38:0] req_epoch_seconds,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [13:0]        rsp_year,
   output logic [3:0]         rsp_month,
   output logic [4:0]         rsp_day_of_month,
   output logic [4:0]         rsp_hour,
   output logic [5:0]         rsp_minute,
   output logic [5:0]         rsp_second,
   output logic [2:0]         rsp_weekday,
   output logic               rsp_out_of_range
);
   import es2c_pkg::*;

   es2c_item_type item;
   logic          item_valid;
   logic          deq;

   // The front classifies each beat and queues it for the pipeline.
   es2c_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_epoch_seconds (req_epoch_seconds),
      .req_full          (req_full),
      .deq               (deq),
      .item              (item),
      .item_valid        (item_valid)
   );

   // The back pipeline does the arithmetic and drives the result ports.
   es2c_back u_back (
      .clock            (clock),
      .reset            (reset),
      .item             (item),
      .item_valid       (item_valid),
      .deq              (deq),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_hour         (rsp_hour),
      .rsp_minute       (rsp_minute),
      .rsp_second       (rsp_second),
      .rsp_weekday      (rsp_weekday),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

[sv/es2c_checker.sv]
// Port-level checks of the epoch to calendar core and their binding.
`include "epoch_seconds_to_calendar_core_defines.svh"

module es2c_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_push,
   input logic               req_full,
   input logic signed [38:0] req_epoch_seconds,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input logic [13:0]        rsp_year,
   input logic [3:0]         rsp_month,
   input logic [4:0]         rsp_day_of_month,
   input logic [4:0]         rsp_hour,
   input logic [5:0]         rsp_minute,
   input logic [5:0]         rsp_second,
   input logic [2:0]         rsp_weekday,
   input logic               rsp_out_of_range
);

   // A flagged beat carries no date or time.
   `ES2C_ASSERT(a_oor_zero, (!rsp_empty && rsp_out_of_range) |-> (rsp_year == 14'd0 && rsp_month == 4'd0 && rsp_day_of_month == 5'd0 && rsp_hour == 5'd0 && rsp_minute == 6'd0 && rsp_second == 6'd0 && rsp_weekday == 3'd0), "out of range beat has nonzero fields")

   // A good beat has every field inside its calendar range.
   `ES2C_ASSERT(a_fields_legal, (!rsp_empty && !rsp_out_of_range) |-> (rsp_year <= 14'd9999 && rsp_month >= 4'd1 && rsp_month <= 4'd12 && rsp_day_of_month >= 5'd1 && rsp_hour <= 5'd23 && rsp_minute <= 6'd59 && rsp_second <= 6'd59 && rsp_weekday != 3'd0), "result field out of calendar range")

   // A result that is not popped stays in place, with its year, day of month, second and weekday stable.
   `ES2C_ASSERT(a_hold, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_year) && $stable(rsp_day_of_month) && $stable(rsp_second) && $stable(rsp_weekday)), "unpopped result changed")

   // Reset leaves both sides empty.
   `ES2C_ASSERT(a_reset_empty, $past(reset) |-> (rsp_empty && !req_full), "core not empty after reset")

endmodule

bind epoch_seconds_to_calendar_core es2c_checker u_es2c_checker (.*);
